FILE: rtl/modbus_rtu_response_parser_assert.svh
// ----------------------------------------------------------------------------
// modbus rtu response parser assertion macros
// immediate-consequent and next-cycle checks on clk with rst_n disable
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH

// consequent holds in the same cycle
`define MRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// shared types, constants and functions of the modbus rtu response parser
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic REG_SLAVE_ID = 1'b0;
  localparam logic REG_EXP_ECHO = 1'b1;

  localparam logic [7:0]  FN_READ_FIRST = 8'd1;
  localparam logic [7:0]  FN_READ_LAST  = 8'd4;
  localparam logic [7:0]  FN_COIL_WRITE = 8'd5;
  localparam logic [7:0]  FN_REG_WRITE  = 8'd6;
  localparam logic [7:0]  ECHO_LEN      = 8'd8;
  localparam logic [7:0]  COUNT_MAX     = 8'hFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_COUNT = 3'd2,
    PH_DATA  = 3'd3,
    PH_RCRC1 = 3'd4,
    PH_RCRC2 = 3'd5,
    PH_ECHO  = 3'd6,
    PH_WAIT  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ_DATA = 2'd0,
    KIND_READ_END  = 2'd1,
    KIND_WRITE_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic       event_req;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } in_slot_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] reply_slave;
    logic [7:0] function_code;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic       crc_ok;
    logic       write_ok;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } res_slot_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] echo_byte(input logic [63:0] echo, input logic [2:0] idx);
    logic [7:0][7:0] lanes;
    lanes = echo;
    return lanes[3'd7 - idx];
  endfunction

endpackage

FILE: rtl/mrp_in_if.sv
// ----------------------------------------------------------------------------
// mrp_in_if
// input channel: received byte or frame-gap event with valid/ready
// ----------------------------------------------------------------------------
interface mrp_in_if;
  logic       valid;
  logic       ready;
  logic       event_req;
  logic [7:0] rx_byte;

  modport source (output valid, output event_req, output rx_byte, input ready);
  modport sink   (input valid, input event_req, input rx_byte, output ready);
endinterface

FILE: rtl/mrp_out_if.sv
// ----------------------------------------------------------------------------
// mrp_out_if
// result channel: parsed data byte or frame end with valid/ready
// ----------------------------------------------------------------------------
interface mrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] reply_slave;
  logic [7:0] function_code;
  logic [7:0] byte_index;
  logic [7:0] data_byte;
  logic       crc_ok;
  logic       write_ok;

  modport source (output valid, output result_kind, output reply_slave,
                  output function_code, output byte_index, output data_byte,
                  output crc_ok, output write_ok, input ready);
  modport sink   (input valid, input result_kind, input reply_slave,
                  input function_code, input byte_index, input data_byte,
                  input crc_ok, input write_ok, output ready);
endinterface

FILE: rtl/mrp_apb_regs.sv
// ----------------------------------------------------------------------------
// mrp_apb_regs
// apb configuration registers: slave address and expected write echo
// ----------------------------------------------------------------------------
module mrp_apb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    slave_id,
  output logic [63:0]                   expected_echo
);

  logic [7:0]  slave_id_r;
  logic [63:0] expected_echo_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r      <= '0;
      expected_echo_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        mrp_pkg::REG_SLAVE_ID: slave_id_r      <= pwdata[7:0];
        mrp_pkg::REG_EXP_ECHO: expected_echo_r <= pwdata[63:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mrp_pkg::REG_SLAVE_ID: prdata = {56'h0, slave_id_r};
      mrp_pkg::REG_EXP_ECHO: prdata = expected_echo_r;
      default:               prdata = '0;
    endcase
  end

  assign slave_id      = slave_id_r;
  assign expected_echo = expected_echo_r;

endmodule

FILE: rtl/mrp_in_stage.sv
// ----------------------------------------------------------------------------
// mrp_in_stage
// input register: captures one word per cycle while the parse stage advances
// ----------------------------------------------------------------------------
module mrp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  mrp_in_if.sink            in_ch,
  input  logic              adv,
  output mrp_pkg::in_slot_t slot
);

  logic              valid_r;
  mrp_pkg::in_word_t word_r;

  assign in_ch.ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r.event_req <= in_ch.event_req;
      word_r.rx_byte   <= in_ch.rx_byte;
    end
  end

  assign slot.valid = valid_r;
  assign slot.word  = word_r;

endmodule

FILE: rtl/mrp_parse_core.sv
// ----------------------------------------------------------------------------
// mrp_parse_core
// frame parse state machine with running crc-16 and echo compare
// ----------------------------------------------------------------------------
module mrp_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  mrp_pkg::in_slot_t  slot,
  input  logic               adv,
  input  logic [7:0]         slave_id,
  input  logic [63:0]        expected_echo,
  output mrp_pkg::res_slot_t res
);

  mrp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      frame_count_r, frame_count_nxt;
  logic [7:0]      data_index_r, data_index_nxt;
  logic [7:0]      byte_total_r, byte_total_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic            mismatch_r, mismatch_nxt;
  logic [7:0]      held_function_r, held_function_nxt;

  logic        fire;
  logic [7:0]  b;
  logic [7:0]  fc_base, fc_take;
  logic [15:0] crc_base, crc_take;
  logic        mm_base, mm_take;

  assign fire = slot.valid && adv;
  assign b    = slot.word.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= mrp_pkg::PH_ADDR;
      frame_count_r   <= '0;
      data_index_r    <= 8'd1;
      byte_total_r    <= '0;
      crc_r           <= mrp_pkg::CRC_INIT;
      mismatch_r      <= 1'b0;
      held_function_r <= '0;
    end else begin
      phase_r         <= phase_nxt;
      frame_count_r   <= frame_count_nxt;
      data_index_r    <= data_index_nxt;
      byte_total_r    <= byte_total_nxt;
      crc_r           <= crc_nxt;
      mismatch_r      <= mismatch_nxt;
      held_function_r <= held_function_nxt;
    end
  end

  // byte intake: address byte restarts the frame counters
  always_comb begin
    fc_base  = frame_count_r;
    crc_base = crc_r;
    mm_base  = mismatch_r;
    if (phase_r == mrp_pkg::PH_ADDR) begin
      fc_base  = '0;
      crc_base = mrp_pkg::CRC_INIT;
      mm_base  = 1'b0;
    end
    fc_take  = (fc_base == mrp_pkg::COUNT_MAX) ? fc_base : fc_base + 8'd1;
    crc_take = mrp_pkg::crc_byte(crc_base, b);
    mm_take  = mm_base ||
               ((fc_base < mrp_pkg::ECHO_LEN) &&
                (b != mrp_pkg::echo_byte(expected_echo, fc_base[2:0])));
  end

  always_comb begin
    phase_nxt         = phase_r;
    frame_count_nxt   = frame_count_r;
    data_index_nxt    = data_index_r;
    byte_total_nxt    = byte_total_r;
    crc_nxt           = crc_r;
    mismatch_nxt      = mismatch_r;
    held_function_nxt = held_function_r;

    res.valid                = 1'b0;
    res.result.result_kind   = mrp_pkg::KIND_READ_DATA;
    res.result.reply_slave   = slave_id;
    res.result.function_code = held_function_r;
    res.result.byte_index    = '0;
    res.result.data_byte     = '0;
    res.result.crc_ok        = 1'b0;
    res.result.write_ok      = 1'b0;

    if (fire) begin
      if (slot.word.event_req) begin
        phase_nxt         = mrp_pkg::PH_ADDR;
        frame_count_nxt   = '0;
        data_index_nxt    = 8'd1;
        byte_total_nxt    = '0;
        crc_nxt           = mrp_pkg::CRC_INIT;
        mismatch_nxt      = 1'b0;
        held_function_nxt = '0;
      end else begin
        case (phase_r)
          mrp_pkg::PH_ADDR: begin
            if (b == slave_id) begin
              frame_count_nxt = fc_take;
              crc_nxt         = crc_take;
              mismatch_nxt    = mm_take;
              phase_nxt       = mrp_pkg::PH_FUNC;
            end else begin
              phase_nxt = mrp_pkg::PH_WAIT;
            end
          end
          mrp_pkg::PH_FUNC: begin
            frame_count_nxt   = fc_take;
            crc_nxt           = crc_take;
            mismatch_nxt      = mm_take;
            held_function_nxt = b;
            if (b >= mrp_pkg::FN_READ_FIRST && b <= mrp_pkg::FN_READ_LAST) begin
              phase_nxt = mrp_pkg::PH_COUNT;
            end else if (b == mrp_pkg::FN_COIL_WRITE || b == mrp_pkg::FN_REG_WRITE) begin
              phase_nxt = mrp_pkg::PH_ECHO;
            end else begin
              phase_nxt = mrp_pkg::PH_WAIT;
            end
          end
          mrp_pkg::PH_COUNT: begin
            frame_count_nxt = fc_take;
            crc_nxt         = crc_take;
            mismatch_nxt    = mm_take;
            byte_total_nxt  = b;
            data_index_nxt  = 8'd1;
            phase_nxt       = (b == 8'd0) ? mrp_pkg::PH_WAIT : mrp_pkg::PH_DATA;
          end
          mrp_pkg::PH_DATA: begin
            frame_count_nxt = fc_take;
            crc_nxt         = crc_take;
            mismatch_nxt    = mm_take;
            res.valid              = 1'b1;
            res.result.result_kind = mrp_pkg::KIND_READ_DATA;
            res.result.byte_index  = data_index_r;
            res.result.data_byte   = b;
            if (data_index_r == byte_total_r) begin
              phase_nxt = mrp_pkg::PH_RCRC1;
            end
            data_index_nxt = data_index_r + 8'd1;
          end
          mrp_pkg::PH_RCRC1: begin
            frame_count_nxt = fc_take;
            crc_nxt         = crc_take;
            mismatch_nxt    = mm_take;
            phase_nxt       = mrp_pkg::PH_RCRC2;
          end
          mrp_pkg::PH_RCRC2: begin
            frame_count_nxt = fc_take;
            crc_nxt         = crc_take;
            mismatch_nxt    = mm_take;
            phase_nxt       = mrp_pkg::PH_WAIT;
            res.valid              = 1'b1;
            res.result.result_kind = mrp_pkg::KIND_READ_END;
            res.result.crc_ok      = (crc_take == 16'h0000);
          end
          mrp_pkg::PH_ECHO: begin
            frame_count_nxt = fc_take;
            crc_nxt         = crc_take;
            mismatch_nxt    = mm_take;
            if (fc_take >= mrp_pkg::ECHO_LEN) begin
              phase_nxt              = mrp_pkg::PH_WAIT;
              res.valid              = 1'b1;
              res.result.result_kind = mrp_pkg::KIND_WRITE_END;
              res.result.crc_ok      = (crc_take == 16'h0000);
              res.result.write_ok    = (crc_take == 16'h0000) && !mm_take;
            end
          end
          default: begin
            phase_nxt = mrp_pkg::PH_WAIT;
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/mrp_out_stage.sv
// ----------------------------------------------------------------------------
// mrp_out_stage
// result register: holds one result word until the sink takes it
// ----------------------------------------------------------------------------
module mrp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  mrp_pkg::res_slot_t res,
  output logic               adv,
  mrp_out_if.source          out_ch
);

  logic             valid_r;
  mrp_pkg::result_t result_r;

  assign adv = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      result_r <= res.result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.result_kind   = result_r.result_kind;
  assign out_ch.reply_slave   = result_r.reply_slave;
  assign out_ch.function_code = result_r.function_code;
  assign out_ch.byte_index    = result_r.byte_index;
  assign out_ch.data_byte     = result_r.data_byte;
  assign out_ch.crc_ok        = result_r.crc_ok;
  assign out_ch.write_ok      = result_r.write_ok;

endmodule

FILE: rtl/modbus_rtu_response_parser.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser: master-side modbus rtu reply parser
// path: each input word is registered in the input stage, parsed, then registered in the result stage
// throughput: one word per cycle while the result register is not stalled, as crc and parse are combinational
// reset: synchronous active-low rst_n clears parse state and both registers
// ----------------------------------------------------------------------------
`include "modbus_rtu_response_parser_assert.svh"

module modbus_rtu_response_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  mrp_in_if.sink                         in_ch,
  mrp_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic               adv;
  logic [7:0]         slave_id;
  logic [63:0]        expected_echo;
  mrp_pkg::in_slot_t  slot;
  mrp_pkg::res_slot_t res;

  mrp_apb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .slave_id      (slave_id),
    .expected_echo (expected_echo)
  );

  mrp_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .slot  (slot)
  );

  mrp_parse_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .slot          (slot),
    .adv           (adv),
    .slave_id      (slave_id),
    .expected_echo (expected_echo),
    .res           (res)
  );

  mrp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .adv    (adv),
    .out_ch (out_ch)
  );

  `MRP_ASSERT_SAME(a_stall_blocks_input, slot.valid && !adv, !in_ch.ready, "input taken while stage stalled")
  `MRP_ASSERT_NEXT(a_gap_no_result, slot.valid && adv && slot.word.event_req, !out_ch.valid, "gap word produced a result")
  `MRP_ASSERT_SAME(a_data_fields, out_ch.valid && out_ch.result_kind == mrp_pkg::KIND_READ_DATA, out_ch.byte_index != 8'd0 && !out_ch.crc_ok && !out_ch.write_ok, "bad read data result")
  `MRP_ASSERT_SAME(a_write_ok_scope, out_ch.valid && out_ch.write_ok, out_ch.result_kind == mrp_pkg::KIND_WRITE_END && out_ch.crc_ok, "write_ok outside good write end")

endmodule
